// ----- rtl/teia_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teia_pkg
// shared types and constants of the tei assignment machine
// ----------------------------------------------------------------------------
package teia_pkg;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_AWAIT  = 2'd1,
    ST_VERIFY = 2'd2
  } state_e;

  typedef enum logic [2:0] {
    OP_IDREQ     = 3'd0,
    OP_ASSIGNED  = 3'd1,
    OP_ASSIGNREQ = 3'd2,
    OP_DENIED    = 3'd3,
    OP_CHKREQ    = 3'd4,
    OP_REMOVE    = 3'd5,
    OP_VERIFY    = 3'd6,
    OP_T202      = 3'd7
  } op_e;

  localparam logic [2:0] MT_NONE     = 3'd0;
  localparam logic [2:0] MT_REQUEST  = 3'd1;
  localparam logic [2:0] MT_ASSIGNED = 3'd2;
  localparam logic [2:0] MT_CHK_RES  = 3'd5;
  localparam logic [2:0] MT_VERIFY   = 3'd7;

  localparam logic [6:0] BROADCAST_TEI = 7'd127;
  localparam logic [6:0] NET_TEI_RESET = 7'd100;
  localparam logic [1:0] N202_REQUEST  = 2'd3;
  localparam logic [1:0] N202_VERIFY   = 2'd2;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 48;

  typedef struct packed {
    op_e         op;
    logic [15:0] msg_ri;
    logic [6:0]  msg_ai;
    logic [15:0] fresh_ri;
  } event_t;

  typedef struct packed {
    logic [1:0]  state_now;
    logic        error_ind;
    logic        remove_ind;
    logic [6:0]  assigned_tei;
    logic        assign_ind;
    logic        timer_stop;
    logic        timer_start;
    logic [6:0]  tx_ai;
    logic [15:0] tx_ri;
    logic [2:0]  tx_msg_type;
    logic        tx_valid;
  } result_t;

endpackage

// ----- rtl/teia_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teia_core
// state registers and event decode of the tei assignment machine
// ----------------------------------------------------------------------------
module teia_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [6:0]        cfg_wdata_i,
  input  logic              step_i,
  input  teia_pkg::event_t  evt_i,
  output teia_pkg::result_t res_o
);

  teia_pkg::state_e state_q, state_d;
  logic [15:0]      pending_ri_q, pending_ri_d;
  logic [1:0]       retry_q, retry_d;
  logic [6:0]       own_tei_q, own_tei_d;
  logic             own_valid_q, own_valid_d;
  logic [6:0]       net_tei_q;
  logic             addressed;
  logic [6:0]       verify_ai;

  assign addressed = own_valid_q && ((evt_i.msg_ai == teia_pkg::BROADCAST_TEI) ||
                                     (evt_i.msg_ai == own_tei_q));
  assign verify_ai = own_valid_q ? own_tei_q : teia_pkg::BROADCAST_TEI;

  always_comb begin
    state_d      = state_q;
    pending_ri_d = pending_ri_q;
    retry_d      = retry_q;
    own_tei_d    = own_tei_q;
    own_valid_d  = own_valid_q;
    res_o        = '0;

    if (evt_i.op == teia_pkg::OP_CHKREQ || evt_i.op == teia_pkg::OP_REMOVE) begin
      // check and remove act alike in idle and verifying
      if (state_q != teia_pkg::ST_AWAIT && addressed) begin
        res_o.timer_stop = 1'b1;
        state_d          = teia_pkg::ST_IDLE;
        if (evt_i.op == teia_pkg::OP_CHKREQ) begin
          res_o.tx_valid    = 1'b1;
          res_o.tx_msg_type = teia_pkg::MT_CHK_RES;
          res_o.tx_ri       = evt_i.fresh_ri;
          res_o.tx_ai       = own_tei_q;
        end else begin
          res_o.remove_ind = 1'b1;
          own_valid_d      = 1'b0;
        end
      end
    end else begin
      case (state_q)
        teia_pkg::ST_AWAIT: begin
          if (evt_i.op == teia_pkg::OP_ASSIGNED) begin
            if (evt_i.msg_ri == pending_ri_q) begin
              res_o.timer_stop   = 1'b1;
              res_o.assign_ind   = 1'b1;
              res_o.assigned_tei = evt_i.msg_ai;
              own_tei_d          = evt_i.msg_ai;
              own_valid_d        = 1'b1;
              state_d            = teia_pkg::ST_IDLE;
            end
          end else if (evt_i.op == teia_pkg::OP_T202) begin
            if (retry_q > 2'd1) begin
              retry_d           = retry_q - 2'd1;
              pending_ri_d      = evt_i.fresh_ri;
              res_o.tx_valid    = 1'b1;
              res_o.tx_msg_type = teia_pkg::MT_REQUEST;
              res_o.tx_ri       = evt_i.fresh_ri;
              res_o.tx_ai       = teia_pkg::BROADCAST_TEI;
              res_o.timer_start = 1'b1;
            end else begin
              retry_d         = 2'd0;
              res_o.error_ind = 1'b1;
              state_d         = teia_pkg::ST_IDLE;
            end
          end
        end
        teia_pkg::ST_VERIFY: begin
          if (evt_i.op == teia_pkg::OP_T202) begin
            if (retry_q > 2'd1) begin
              retry_d           = retry_q - 2'd1;
              res_o.tx_valid    = 1'b1;
              res_o.tx_msg_type = teia_pkg::MT_VERIFY;
              res_o.tx_ai       = verify_ai;
              res_o.timer_start = 1'b1;
            end else begin
              // verify failed on the last retry
              retry_d          = 2'd0;
              res_o.remove_ind = 1'b1;
              own_valid_d      = 1'b0;
              state_d          = teia_pkg::ST_IDLE;
            end
          end
        end
        default: begin
          if (evt_i.op == teia_pkg::OP_IDREQ) begin
            if (!own_valid_q) begin
              pending_ri_d      = evt_i.fresh_ri;
              res_o.tx_valid    = 1'b1;
              res_o.tx_msg_type = teia_pkg::MT_REQUEST;
              res_o.tx_ri       = evt_i.fresh_ri;
              res_o.tx_ai       = teia_pkg::BROADCAST_TEI;
              res_o.timer_start = 1'b1;
              retry_d           = teia_pkg::N202_REQUEST;
              state_d           = teia_pkg::ST_AWAIT;
            end
          end else if (evt_i.op == teia_pkg::OP_ASSIGNREQ) begin
            if (own_valid_q) begin
              pending_ri_d      = evt_i.msg_ri;
              res_o.tx_valid    = 1'b1;
              res_o.tx_msg_type = teia_pkg::MT_ASSIGNED;
              res_o.tx_ri       = evt_i.msg_ri;
              res_o.tx_ai       = net_tei_q;
            end
          end else if (evt_i.op == teia_pkg::OP_VERIFY) begin
            res_o.tx_valid    = 1'b1;
            res_o.tx_msg_type = teia_pkg::MT_VERIFY;
            res_o.tx_ai       = verify_ai;
            res_o.timer_start = 1'b1;
            retry_d           = teia_pkg::N202_VERIFY;
            state_d           = teia_pkg::ST_VERIFY;
          end
        end
      endcase
    end
    res_o.state_now = state_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= teia_pkg::ST_IDLE;
      pending_ri_q <= '0;
      retry_q      <= '0;
      own_tei_q    <= '0;
      own_valid_q  <= 1'b0;
    end else if (step_i) begin
      state_q      <= state_d;
      pending_ri_q <= pending_ri_d;
      retry_q      <= retry_d;
      own_tei_q    <= own_tei_d;
      own_valid_q  <= own_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      net_tei_q <= teia_pkg::NET_TEI_RESET;
    end else if (cfg_we_i) begin
      net_tei_q <= cfg_wdata_i;
    end
  end

endmodule

// ----- rtl/teia_out_reg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// teia_out_reg
// result register of the master-side stream
// ----------------------------------------------------------------------------
module teia_out_reg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                load_i,
  input  teia_pkg::result_t                   res_i,
  input  logic                                tready_i,
  output logic                                full_o,
  output logic [teia_pkg::OUT_DATA_W-1:0]     tdata_o
);

  localparam int unsigned ResW = $bits(teia_pkg::result_t);

  logic              valid_q, valid_d;
  teia_pkg::result_t data_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign full_o  = valid_q;
  assign tdata_o = {{(teia_pkg::OUT_DATA_W - ResW){1'b0}}, data_q};

endmodule

// ----- rtl/tei_assignment_fsm_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tei_assignment_fsm_unit
// q.921 tei management machine: one event word in, one result word out
// ----------------------------------------------------------------------------
//  channel   | dir | handshake             | payload
//  s_axis    | in  | tvalid / tready       | tuser event code, tdata event fields
//  m_axis    | out | tvalid / tready       | tdata result fields
//  cfg       | in  | cfg_we_i (no ready)   | cfg_wdata_i net-side assigned tei
//
//  an event word is held in the input register, is decoded against the
//  state registers and lands in the result register; state updates as it moves
//  m_axis_tvalid rises once the word has moved from the input register into the
//  result register; throughput one word per cycle while m_axis_tready stays
//  high, set by the single decode pass between input and result registers
//  a full result register that is not taken stalls the input register, which
//  then stalls s_axis; both stages drain freely once m_axis_tready is high
//  reset: idle state, no tei held, both stages empty, cfg register at 100
// ----------------------------------------------------------------------------
module tei_assignment_fsm_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  // event stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [2:0]  s_axis_tuser,   // op
  input  logic [39:0] s_axis_tdata,   // msg_ri[15:0], msg_ai[22:16], fresh_ri[38:23], pad
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // tx_valid[0], tx_msg_type[3:1], tx_ri[19:4],
                                      // tx_ai[26:20], timer_start[27], timer_stop[28],
                                      // assign_ind[29], assigned_tei[36:30],
                                      // remove_ind[37], error_ind[38], state_now[40:39], pad
);

  // input register
  logic              in_valid_q, in_valid_d;
  teia_pkg::event_t  in_evt_q;
  logic              advance;
  logic              out_full;
  teia_pkg::result_t res;

  // the decoded word moves on when the result register is empty or draining
  assign advance       = in_valid_q && (!out_full || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tvalid && s_axis_tready) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // event payload, op arrives on tuser
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_evt_q.op       <= teia_pkg::op_e'(s_axis_tuser);
      in_evt_q.msg_ri   <= s_axis_tdata[15:0];
      in_evt_q.msg_ai   <= s_axis_tdata[22:16];
      in_evt_q.fresh_ri <= s_axis_tdata[38:23];
    end
  end

  // decode and state update
  teia_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (advance),
    .evt_i       (in_evt_q),
    .res_o       (res)
  );

  // result register
  teia_out_reg u_out_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (advance),
    .res_i    (res),
    .tready_i (m_axis_tready),
    .full_o   (out_full),
    .tdata_o  (m_axis_tdata)
  );

  assign m_axis_tvalid = out_full;

endmodule

// ----- bench/tei_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tei_result_checker
// watches the event and result streams of the tei assignment machine, keeps
// its own copy of the machine state, predicts one result word per accepted
// event word and compares each returned result field by field
// ----------------------------------------------------------------------------
module tei_result_checker
  import teia_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [6:0]  cfg_wdata_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [2:0]  s_tuser_i,
  input  logic [39:0] s_tdata_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [47:0] m_tdata_i,
  output int          mismatch_count_o,
  output int          outstanding_o
);

  state_e      st;
  logic [15:0] pend_ri;
  logic [1:0]  retries;
  logic [6:0]  tei;
  logic        tei_held;
  logic [6:0]  net_tei;

  result_t expected_results[$];
  int      mismatches = 0;
  int      outstanding = 0;

  assign mismatch_count_o = mismatches;
  assign outstanding_o    = outstanding;

  function automatic result_t with_msg(input result_t r, input logic [2:0] mtype,
                                       input logic [15:0] ri, input logic [6:0] ai);
    result_t o;
    o             = r;
    o.tx_valid    = 1'b1;
    o.tx_msg_type = mtype;
    o.tx_ri       = ri;
    o.tx_ai       = ai;
    return o;
  endfunction

  // one event against the tracked machine state; updates that state
  function automatic result_t predict_tei_result(input op_e op, input logic [15:0] mri,
                                                 input logic [6:0] mai,
                                                 input logic [15:0] rri);
    result_t r;
    r = '0;
    if (op == OP_CHKREQ || op == OP_REMOVE) begin
      // handled alike outside the awaiting state, only when addressed
      if (st != ST_AWAIT && tei_held && (mai == BROADCAST_TEI || mai == tei)) begin
        r.timer_stop = 1'b1;
        st = ST_IDLE;
        if (op == OP_CHKREQ) begin
          r = with_msg(r, MT_CHK_RES, rri, tei);
        end else begin
          r.remove_ind = 1'b1;
          tei_held = 1'b0;
        end
      end
    end else begin
      case (st)
        ST_IDLE: begin
          if (op == OP_IDREQ && !tei_held) begin
            pend_ri = rri;
            r = with_msg(r, MT_REQUEST, rri, BROADCAST_TEI);
            r.timer_start = 1'b1;
            st = ST_AWAIT;
            retries = N202_REQUEST;
          end else if (op == OP_ASSIGNREQ && tei_held) begin
            pend_ri = mri;
            r = with_msg(r, MT_ASSIGNED, mri, net_tei);
          end else if (op == OP_VERIFY) begin
            r = with_msg(r, MT_VERIFY, 16'd0, tei_held ? tei : BROADCAST_TEI);
            r.timer_start = 1'b1;
            st = ST_VERIFY;
            retries = N202_VERIFY;
          end
        end
        ST_AWAIT: begin
          if (op == OP_ASSIGNED && mri == pend_ri) begin
            r.timer_stop   = 1'b1;
            r.assign_ind   = 1'b1;
            r.assigned_tei = mai;
            tei = mai;
            tei_held = 1'b1;
            st = ST_IDLE;
          end else if (op == OP_T202) begin
            if (retries > 2'd1) begin
              retries = retries - 2'd1;
              pend_ri = rri;
              r = with_msg(r, MT_REQUEST, rri, BROADCAST_TEI);
              r.timer_start = 1'b1;
            end else begin
              retries = 2'd0;
              r.error_ind = 1'b1;
              st = ST_IDLE;
            end
          end
        end
        default: begin
          if (op == OP_T202) begin
            if (retries > 2'd1) begin
              retries = retries - 2'd1;
              r = with_msg(r, MT_VERIFY, 16'd0, tei_held ? tei : BROADCAST_TEI);
              r.timer_start = 1'b1;
            end else begin
              // verify failed: the tei is dropped
              retries = 2'd0;
              r.remove_ind = 1'b1;
              tei_held = 1'b0;
              st = ST_IDLE;
            end
          end
        end
      endcase
    end
    r.state_now = st;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t got;
    if (!rst_ni) begin
      st       = ST_IDLE;
      pend_ri  = '0;
      retries  = '0;
      tei      = '0;
      tei_held = 1'b0;
      net_tei  = NET_TEI_RESET;
      expected_results.delete();
    end else begin
      if (cfg_we_i) net_tei = cfg_wdata_i;
      if (s_tvalid_i && s_tready_i) begin
        expected_results.push_back(predict_tei_result(op_e'(s_tuser_i), s_tdata_i[15:0],
                                                      s_tdata_i[22:16], s_tdata_i[38:23]));
      end
      if (m_tvalid_i && m_tready_i) begin
        got = result_t'(m_tdata_i[40:0]);
        if (expected_results.size() == 0) begin
          $display("%0t: result word with none expected, expected none, actual %h",
                   $time, m_tdata_i);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("tx_valid",     want.tx_valid,     got.tx_valid);
          check_field("tx_msg_type",  want.tx_msg_type,  got.tx_msg_type);
          check_field("tx_ri",        want.tx_ri,        got.tx_ri);
          check_field("tx_ai",        want.tx_ai,        got.tx_ai);
          check_field("timer_start",  want.timer_start,  got.timer_start);
          check_field("timer_stop",   want.timer_stop,   got.timer_stop);
          check_field("assign_ind",   want.assign_ind,   got.assign_ind);
          check_field("assigned_tei", want.assigned_tei, got.assigned_tei);
          check_field("remove_ind",   want.remove_ind,   got.remove_ind);
          check_field("error_ind",    want.error_ind,    got.error_ind);
          check_field("state_now",    want.state_now,    got.state_now);
        end
      end
    end
    outstanding = expected_results.size();
  end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stimulus and verdict for the tei assignment machine: a directed opening run
// through every event and corner of the state machine, then four random
// phases of mostly well-formed assignment, verify, check and remove sequences
// under varying sender and receiver idling; a separate checker predicts and
// compares every result word
// ----------------------------------------------------------------------------
module tb_top;
  import teia_pkg::*;

  localparam int CYCLE_LIMIT = 200000;  // far above the slowest correct run
  localparam int HOLD_CYCLES = 64;      // long receiver hold-off
  localparam int PHASE_WORDS = 120;     // random event words per phase

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [6:0]  cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [2:0]  s_axis_tuser;   // op
  logic [39:0] s_axis_tdata;   // msg_ri, msg_ai, fresh_ri, pad
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // result fields, tx_valid lowest

  int mismatch_count;
  int outstanding;

  // stimulus knobs, shared between the sender and the receiver process
  int   send_idle_pct;
  int   recv_stall_pct;
  bit   hold_off_req;
  int   sent_count;
  int   cycle_count;
  logic [6:0] held_tei;   // last tei handed out, used to aim check and remove

  tei_assignment_fsm_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  tei_result_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .s_tvalid_i       (s_axis_tvalid),
    .s_tready_i       (s_axis_tready),
    .s_tuser_i        (s_axis_tuser),
    .s_tdata_i        (s_axis_tdata),
    .m_tvalid_i       (m_axis_tvalid),
    .m_tready_i       (m_axis_tready),
    .m_tdata_i        (m_axis_tdata),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run guard: a hang anywhere ends here
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // receiver: random stalls, or one long hold-off on request so the block
  // fills both stages and pushes back on the sender
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // field values that hit the extremes now and then
  function automatic logic [15:0] rand_ri();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return 16'h0000;
    if (pick == 1) return 16'hffff;
    return 16'($urandom_range(65535));
  endfunction

  function automatic logic [6:0] rand_tei();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return 7'd0;
    if (pick == 1) return BROADCAST_TEI;
    return 7'($urandom_range(127));
  endfunction

  // one event word; entered and left at a falling edge
  task automatic send_event(input op_e op, input logic [15:0] mri, input logic [6:0] mai,
                            input logic [15:0] rri);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {1'b0, rri, mai, mri};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    sent_count++;
  endtask

  // sender goes quiet until every predicted word has come back
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
  endtask

  task automatic write_net_tei(input logic [6:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // mostly protocol-shaped sequences with random content, some plain noise
  task automatic run_random_events(input int n);
    int          stop_at;
    int          pick;
    logic [15:0] ri;
    logic [6:0]  ai;
    stop_at = sent_count + n;
    while (sent_count < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        // id request, a few expiries, then the network answer
        ri = rand_ri();
        send_event(OP_IDREQ, rand_ri(), rand_tei(), ri);
        repeat ($urandom_range(3)) begin
          ri = rand_ri();
          send_event(OP_T202, rand_ri(), rand_tei(), ri);
        end
        ai = rand_tei();
        if ($urandom_range(9) != 0) begin
          held_tei = ai;
          send_event(OP_ASSIGNED, ri, ai, rand_ri());
        end else begin
          send_event(OP_ASSIGNED, ri + 16'($urandom_range(65535, 1)), ai, rand_ri());
        end
      end else if (pick < 45) begin
        // verify with some expiries, possibly to failure
        send_event(OP_VERIFY, rand_ri(), rand_tei(), rand_ri());
        repeat ($urandom_range(3)) send_event(OP_T202, rand_ri(), rand_tei(), rand_ri());
      end else if (pick < 65) begin
        // check or remove, mostly addressed to the held tei or the group
        pick = $urandom_range(3);
        ai = (pick < 2) ? held_tei : (pick == 2) ? BROADCAST_TEI : rand_tei();
        send_event(op_e'($urandom_range(1) ? OP_CHKREQ : OP_REMOVE), rand_ri(), ai,
                   rand_ri());
      end else if (pick < 75) begin
        send_event(OP_ASSIGNREQ, rand_ri(), rand_tei(), rand_ri());
      end else begin
        send_event(op_e'($urandom_range(7)), rand_ri(), rand_tei(), rand_ri());
      end
    end
  endtask

  task automatic run_phase(input int send_pct, input int recv_pct, input logic [6:0] tei_cfg);
    // config only while the block is empty
    wait_results_drained();
    repeat (4) @(negedge clk_i);
    write_net_tei(tei_cfg);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    run_random_events(PHASE_WORDS / 4);
    wait_results_drained();
    run_random_events(PHASE_WORDS / 4);
    hold_off_req = 1'b1;
    run_random_events(PHASE_WORDS / 2);
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tuser   = OP_IDREQ;
    s_axis_tdata   = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_req   = 1'b0;
    sent_count     = 0;
    held_tei       = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: events with no meaning while idle and no tei held
    send_event(OP_T202,      16'h0000, 7'd0,          16'h0000);
    send_event(OP_ASSIGNED,  16'hffff, 7'd127,        16'hffff);
    send_event(OP_DENIED,    16'h0000, 7'd0,          16'h0000);
    send_event(OP_CHKREQ,    16'h0000, BROADCAST_TEI, 16'h0000);
    send_event(OP_REMOVE,    16'h0000, BROADCAST_TEI, 16'h0000);
    send_event(OP_ASSIGNREQ, 16'hffff, 7'd0,          16'h0000);
    // verify without a tei goes to the group, then fails on the last expiry
    send_event(OP_VERIFY,    16'h0000, 7'd0,          16'h0000);
    send_event(OP_T202,      16'h0000, 7'd0,          16'h0000);
    send_event(OP_T202,      16'h0000, 7'd0,          16'h0000);
    // id request; wrong reference and other events ignored while awaiting, an expiry resends, then tei 0 is assigned
    send_event(OP_IDREQ,     16'h0000, 7'd0,          16'hffff);
    send_event(OP_ASSIGNED,  16'h0000, 7'd5,          16'h0000);
    send_event(OP_IDREQ,     16'h0000, 7'd0,          16'h1111);
    send_event(OP_CHKREQ,    16'h0000, BROADCAST_TEI, 16'h0000);
    send_event(OP_T202,      16'hffff, 7'd0,          16'h0000);
    send_event(OP_ASSIGNED,  16'h0000, 7'd0,          16'hffff);
    // tei 0 held: id request ignored, network reply, check requests
    send_event(OP_IDREQ,     16'h0000, 7'd0,          16'h2222);
    send_event(OP_ASSIGNREQ, 16'hffff, 7'd0,          16'h0000);
    send_event(OP_CHKREQ,    16'h0000, 7'd5,          16'h0000);
    send_event(OP_CHKREQ,    16'h0000, BROADCAST_TEI, 16'hffff);
    send_event(OP_CHKREQ,    16'h0000, 7'd0,          16'h0000);
    // verify with a tei held, ended by a check, then by a group remove
    send_event(OP_VERIFY,    16'hffff, 7'd127,        16'hffff);
    send_event(OP_CHKREQ,    16'h0000, 7'd0,          16'h1234);
    send_event(OP_VERIFY,    16'h0000, 7'd0,          16'h0000);
    send_event(OP_REMOVE,    16'h0000, BROADCAST_TEI, 16'h0000);
    // all retries run out while awaiting
    send_event(OP_IDREQ,     16'h0000, 7'd0,          16'h1234);
    send_event(OP_T202,      16'h0000, 7'd0,          16'h5678);
    send_event(OP_T202,      16'h0000, 7'd0,          16'h9abc);
    send_event(OP_T202,      16'h0000, 7'd0,          16'hdef0);
    // assign the group value itself
    send_event(OP_IDREQ,     16'h0000, 7'd0,          16'h4321);
    send_event(OP_ASSIGNED,  16'h4321, 7'd127,        16'h0000);
    held_tei = 7'd127;

    // random phases: none, sender idle, receiver stall, both
    run_phase(0,  0,  7'd0);
    run_phase(51, 0,  7'd126);
    run_phase(0,  51, 7'($urandom_range(126)));
    run_phase(29, 29, 7'($urandom_range(126)));

    wait_results_drained();
    repeat (8) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
